FILE: hdl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, constants and calendar helper functions for the clock core.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int REQ_W      = 2;
  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int TPS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_FIX = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TPS          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUMMER_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUMMER_LAST  = 2'd2;

  localparam logic [TPS_W-1:0]   TPS_RESET          = 16'd1000;
  localparam logic [MONTH_W-1:0] SUMMER_FIRST_RESET = 4'd3;
  localparam logic [MONTH_W-1:0] SUMMER_LAST_RESET  = 4'd10;
  localparam logic [YEAR_W-1:0]  YEAR_RESET         = 14'd2025;

  localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;
  localparam logic [6:0]  SEC_PER_MIN     = 7'd60;
  localparam logic [5:0]  HOURS_PER_DAY   = 6'd24;
  localparam logic [14:0] YEAR_MAX        = 15'd9999;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } time_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    time_t            tm;
    logic             leap;
  } item_t;

  typedef struct packed {
    logic [TPS_W-1:0]   tps;
    logic [MONTH_W-1:0] summer_first;
    logic [MONTH_W-1:0] summer_last;
  } cfg_t;

  // year divisible by 25, by folding powers of two modulo 25
  function automatic logic div25(input logic [YEAR_W-1:0] y);
    logic [8:0] s;
    logic [7:0] t;
    begin
      s = {2'b00, y[13:7]} + {1'b0, y[13:7], 1'b0} + {2'b00, y[6:0]};
      t = {1'b0, s[8:5], 3'b000} - {4'b0000, s[8:5]} + {3'b000, s[4:0]};
      return (t == 8'd0) || (t == 8'd25) || (t == 8'd50) || (t == 8'd75) ||
             (t == 8'd100) || (t == 8'd125);
    end
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic z25;
    begin
      z25 = div25(y);
      return ((y[1:0] == 2'b00) && !z25) || ((y[3:0] == 4'b0000) && z25);
    end
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic lp);
    logic [MONTH_W-1:0] idx;
    begin
      idx = m - 4'd1;
      if (m == 4'd0 || {1'b0, m} > MONTHS_PER_YEAR) begin
        return 5'd31;
      end else if (m == FEBRUARY && lp) begin
        return 5'd29;
      end else begin
        return MONTH_LEN[idx];
      end
    end
  endfunction

  function automatic time_t next_date(input time_t t, input logic lp);
    time_t       r;
    logic [5:0]  d1;
    logic [4:0]  m1;
    logic [14:0] y1;
    begin
      r  = t;
      d1 = {1'b0, t.day} + 6'd1;
      m1 = {1'b0, t.month} + 5'd1;
      y1 = {1'b0, t.year} + 15'd1;
      if (d1 > {1'b0, days_in(t.month, lp)}) begin
        r.day = 5'd1;
        if (m1 > MONTHS_PER_YEAR) begin
          r.month = 4'd1;
          r.year  = (y1 > YEAR_MAX) ? '0 : y1[YEAR_W-1:0];
        end else begin
          r.month = m1[MONTH_W-1:0];
        end
      end else begin
        r.day = d1[DAY_W-1:0];
      end
      return r;
    end
  endfunction

endpackage

FILE: hdl/ccs_cmd_if.sv
// ----------------------------------------------------------------------------
// ccs_cmd_if
// Request channel: tick, tick with fix, or set time.
// ----------------------------------------------------------------------------
interface ccs_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ccs_pkg::REQ_W-1:0]    req_type;
  logic [ccs_pkg::YEAR_W-1:0]   new_year;
  logic [ccs_pkg::MONTH_W-1:0]  new_month;
  logic [ccs_pkg::DAY_W-1:0]    new_day;
  logic [ccs_pkg::HOUR_W-1:0]   new_hour;
  logic [ccs_pkg::MIN_W-1:0]    new_minute;
  logic [ccs_pkg::SEC_W-1:0]    new_second;

  modport source (output valid, req_type, new_year, new_month, new_day, new_hour,
                  new_minute, new_second, input ready);
  modport sink (input valid, req_type, new_year, new_month, new_day, new_hour,
                new_minute, new_second, output ready);
endinterface

FILE: hdl/ccs_rsp_if.sv
// ----------------------------------------------------------------------------
// ccs_rsp_if
// Result channel: current time and second flag.
// ----------------------------------------------------------------------------
interface ccs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ccs_pkg::YEAR_W-1:0]   cur_year;
  logic [ccs_pkg::MONTH_W-1:0]  cur_month;
  logic [ccs_pkg::DAY_W-1:0]    cur_day;
  logic [ccs_pkg::HOUR_W-1:0]   cur_hour;
  logic [ccs_pkg::MIN_W-1:0]    cur_minute;
  logic [ccs_pkg::SEC_W-1:0]    cur_second;
  logic                         second_elapsed;

  modport source (output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
                  cur_second, second_elapsed, input ready);
  modport sink (input valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
                cur_second, second_elapsed, output ready);
endinterface

FILE: hdl/ccs_cfg_regs.sv
// ----------------------------------------------------------------------------
// ccs_cfg_regs
// Configuration registers: prescaler count and summer month window.
// ----------------------------------------------------------------------------
module ccs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ccs_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tps          <= ccs_pkg::TPS_RESET;
      cfg.summer_first <= ccs_pkg::SUMMER_FIRST_RESET;
      cfg.summer_last  <= ccs_pkg::SUMMER_LAST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ccs_pkg::CFG_TPS: begin
          cfg.tps <= cfg_data[ccs_pkg::TPS_W-1:0];
        end
        ccs_pkg::CFG_SUMMER_FIRST: begin
          cfg.summer_first <= cfg_data[ccs_pkg::MONTH_W-1:0];
        end
        ccs_pkg::CFG_SUMMER_LAST: begin
          cfg.summer_last <= cfg_data[ccs_pkg::MONTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/ccs_in_stage.sv
// ----------------------------------------------------------------------------
// ccs_in_stage
// Input register for request words, with leap-year flag of the new year.
// ----------------------------------------------------------------------------
module ccs_in_stage (
  input  logic            clk,
  input  logic            rst,
  ccs_cmd_if.sink         cmd,
  input  logic            item_take,
  output logic            item_valid,
  output ccs_pkg::item_t  item
);

  logic accept;

  assign cmd.ready = !item_valid || item_take;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.req       <= cmd.req_type;
      item.tm.year   <= cmd.new_year;
      item.tm.month  <= cmd.new_month;
      item.tm.day    <= cmd.new_day;
      item.tm.hour   <= cmd.new_hour;
      item.tm.minute <= cmd.new_minute;
      item.tm.second <= cmd.new_second;
      item.leap      <= ccs_pkg::is_leap(cmd.new_year);
    end
  end

endmodule

FILE: hdl/ccs_time_core.sv
// ----------------------------------------------------------------------------
// ccs_time_core
// Prescaler, calendar state and single-pass time update into result register.
// ----------------------------------------------------------------------------
module ccs_time_core (
  input  logic            clk,
  input  logic            rst,
  input  ccs_pkg::cfg_t   cfg,
  input  logic            item_valid,
  input  ccs_pkg::item_t  item,
  output logic            item_take,
  ccs_rsp_if.source       rsp
);

  ccs_pkg::time_t                st;
  ccs_pkg::time_t                st_next;
  logic [ccs_pkg::TPS_W-1:0]     tick_count;
  logic [ccs_pkg::TPS_W-1:0]     tick_count_next;
  logic                          elapsed_next;

  ccs_pkg::time_t                base;
  ccs_pkg::time_t                stepped;
  ccs_pkg::time_t                dated;
  logic                          base_leap;
  logic                          is_set;
  logic                          done;
  logic                          fix;
  logic                          summer;
  logic [ccs_pkg::TPS_W:0]       tick_inc;
  logic [5:0]                    h1;
  logic [5:0]                    h2;
  logic [ccs_pkg::HOUR_W-1:0]    hour_a;
  logic                          adv_a;
  logic [6:0]                    s1;
  logic [6:0]                    mi1;
  logic                          sec_wrap;
  logic                          min_wrap;
  logic                          hr_wrap;

  assign item_take = item_valid && (!rsp.valid || rsp.ready);

  always_comb begin
    is_set   = (item.req == ccs_pkg::REQ_SET);
    tick_inc = {1'b0, tick_count} + 17'd1;
    done     = (tick_inc >= {1'b0, cfg.tps});
    fix      = !is_set && done && (item.req == ccs_pkg::REQ_FIX);
    base     = fix ? item.tm : st;
    base_leap = fix ? item.leap : ccs_pkg::is_leap(st.year);
    summer   = fix && (item.tm.month >= cfg.summer_first) &&
               (item.tm.month <= cfg.summer_last);

    // summer hour
    h1     = {1'b0, base.hour} + 6'd1;
    adv_a  = 1'b0;
    hour_a = base.hour;
    if (summer) begin
      if (h1 >= ccs_pkg::HOURS_PER_DAY) begin
        hour_a = '0;
        adv_a  = 1'b1;
      end else begin
        hour_a = h1[ccs_pkg::HOUR_W-1:0];
      end
    end

    // one second step
    s1       = {1'b0, base.second} + 7'd1;
    mi1      = {1'b0, base.minute} + 7'd1;
    h2       = {1'b0, hour_a} + 6'd1;
    sec_wrap = (s1 >= ccs_pkg::SEC_PER_MIN);
    min_wrap = (mi1 >= ccs_pkg::SEC_PER_MIN);
    hr_wrap  = (h2 >= ccs_pkg::HOURS_PER_DAY);

    stepped        = base;
    stepped.hour   = hour_a;
    stepped.second = sec_wrap ? '0 : s1[ccs_pkg::SEC_W-1:0];
    if (sec_wrap) begin
      stepped.minute = min_wrap ? '0 : mi1[ccs_pkg::MIN_W-1:0];
      if (min_wrap) begin
        stepped.hour = hr_wrap ? '0 : h2[ccs_pkg::HOUR_W-1:0];
      end
    end

    // at most one day step per word
    dated = ccs_pkg::next_date(base, base_leap);
    if (adv_a || (sec_wrap && min_wrap && hr_wrap)) begin
      stepped.day   = dated.day;
      stepped.month = dated.month;
      stepped.year  = dated.year;
    end

    if (is_set) begin
      st_next         = item.tm;
      tick_count_next = '0;
      elapsed_next    = 1'b0;
    end else if (done) begin
      st_next         = stepped;
      tick_count_next = '0;
      elapsed_next    = 1'b1;
    end else begin
      st_next         = st;
      tick_count_next = tick_inc[ccs_pkg::TPS_W-1:0];
      elapsed_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.year    <= ccs_pkg::YEAR_RESET;
      st.month   <= 4'd1;
      st.day     <= 5'd1;
      st.hour    <= '0;
      st.minute  <= '0;
      st.second  <= '0;
      tick_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (item_take) begin
        st         <= st_next;
        tick_count <= tick_count_next;
      end
      if (item_take) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      rsp.cur_year       <= st_next.year;
      rsp.cur_month      <= st_next.month;
      rsp.cur_day        <= st_next.day;
      rsp.cur_hour       <= st_next.hour;
      rsp.cur_minute     <= st_next.minute;
      rsp.cur_second     <= st_next.second;
      rsp.second_elapsed <= elapsed_next;
    end
  end

`ifndef ASSERT_OFF
  a_take_gives_word: assert property (@(posedge clk) disable iff (rst)
    item_take |=> rsp.valid)
    else $error("taken word did not reach result register");

  a_second_clears_prescaler: assert property (@(posedge clk) disable iff (rst)
    item_take && !is_set && done |=> tick_count == '0 && rsp.second_elapsed)
    else $error("completed second did not clear prescaler");

  a_set_clears_prescaler: assert property (@(posedge clk) disable iff (rst)
    item_take && is_set |=> tick_count == '0 && !rsp.second_elapsed)
    else $error("set request did not clear prescaler");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !item_take |=> $stable(tick_count) && $stable(st))
    else $error("state changed without a taken word");
`endif

endmodule

FILE: hdl/calendar_clock_with_sync_core.sv
// ----------------------------------------------------------------------------
// calendar_clock_with_sync_core
// Gregorian calendar clock advanced by millisecond ticks, with fix sync.
// ----------------------------------------------------------------------------
// channel  dir  handshake     word
// cmd      in   valid/ready   req_type, new_year .. new_second
// rsp      out  valid/ready   cur_year .. cur_second, second_elapsed
// cfg      in   write enable  ticks_per_second, summer_first/last_month
//
// one word per cycle sustained unless rsp stalls; after accept, a word goes
// through the input register, then a single update pass into the result register
// reset: 2025-01-01 00:00:00, prescaler 0, config defaults; no clearing pass
// rsp stall fills the result register, then the input register, then
// drops cmd.ready
// ----------------------------------------------------------------------------
module calendar_clock_with_sync_core (
  input  logic                             clk,
  input  logic                             rst,
  ccs_cmd_if.sink                          cmd,
  ccs_rsp_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ccs_pkg::cfg_t   cfg;
  ccs_pkg::item_t  item;
  logic            item_valid;
  logic            item_take;

  ccs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ccs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  ccs_time_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .rsp        (rsp)
  );

endmodule

FILE: verif/calendar_clock_with_sync_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_clock_with_sync_core_test
// Self-checking bench for the calendar clock core. Ticks, fix syncs and set
// requests go in with random gaps and result stalls. A built-in calendar
// predictor tracks time, prescaler and summer window, and each result word
// is compared against it. Corner dates, odd field values and prescaler
// settings come first, then random traffic under several configurations.
// ----------------------------------------------------------------------------
module calendar_clock_with_sync_core_test;

  localparam logic [ccs_pkg::REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [ccs_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DAYS_OF_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int CORNER_YEARS [8] = '{0, 1900, 2000, 2023, 2024, 2100, 2400, 9999};

  typedef struct packed {
    ccs_pkg::time_t tm;
    logic           elapsed;
  } clock_reading_t;

  logic clk;
  logic rst;
  logic                           cfg_we;
  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data;

  ccs_cmd_if cmd_ch ();
  ccs_rsp_if rsp_ch ();

  calendar_clock_with_sync_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  ccs_pkg::time_t              cal_now;
  logic [ccs_pkg::TPS_W-1:0]   tick_count;
  logic [ccs_pkg::TPS_W-1:0]   tps_cfg;
  logic [ccs_pkg::MONTH_W-1:0] summer_first;
  logic [ccs_pkg::MONTH_W-1:0] summer_last;

  clock_reading_t clock_readings [$];
  clock_reading_t got_reading;
  clock_reading_t want_reading;
  ccs_pkg::time_t cmd_time;

  int  fail_count;
  int  words_sent;
  int  readings_checked;
  int  seconds_seen;
  int  syncs_seen;
  int  idle_cycles;
  bit  sender_gaps;
  bit  receiver_stalls;

  always #5 clk = ~clk;

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int m, int y);
    logic [3:0] idx;
    idx = 4'(m - 1);
    if (m < 1 || m > 12) return 31;
    if (m == 2 && leap_year(y)) return 29;
    return DAYS_OF_MONTH[idx];
  endfunction

  function automatic void roll_day();
    int d;
    int m;
    int y;
    d = cal_now.day + 1;
    if (d > month_days(cal_now.month, cal_now.year)) begin
      d = 1;
      m = cal_now.month + 1;
      if (m > 12) begin
        m = 1;
        y = cal_now.year + 1;
        cal_now.year = (y > 9999) ? '0 : y[ccs_pkg::YEAR_W-1:0];
      end
      cal_now.month = m[ccs_pkg::MONTH_W-1:0];
    end
    cal_now.day = d[ccs_pkg::DAY_W-1:0];
  endfunction

  function automatic void advance_second();
    int s;
    int mi;
    int h;
    s = cal_now.second + 1;
    if (s < 60) begin
      cal_now.second = s[ccs_pkg::SEC_W-1:0];
      return;
    end
    cal_now.second = 0;
    mi = cal_now.minute + 1;
    if (mi < 60) begin
      cal_now.minute = mi[ccs_pkg::MIN_W-1:0];
      return;
    end
    cal_now.minute = 0;
    h = cal_now.hour + 1;
    if (h < 24) begin
      cal_now.hour = h[ccs_pkg::HOUR_W-1:0];
      return;
    end
    cal_now.hour = 0;
    roll_day();
  endfunction

  function automatic clock_reading_t predict_step(logic [ccs_pkg::REQ_W-1:0] req,
                                                  ccs_pkg::time_t tm);
    logic elapsed;
    int   h;
    elapsed = 1'b0;
    if (req == ccs_pkg::REQ_SET) begin
      cal_now = tm;
      tick_count = '0;
    end else if (tick_count + 1 >= tps_cfg) begin
      tick_count = '0;
      elapsed = 1'b1;
      if (req == ccs_pkg::REQ_FIX) begin
        syncs_seen++;
        cal_now = tm;
        if (cal_now.month >= summer_first && cal_now.month <= summer_last) begin
          h = cal_now.hour + 1;
          if (h >= 24) begin
            cal_now.hour = 0;
            roll_day();
          end else begin
            cal_now.hour = h[ccs_pkg::HOUR_W-1:0];
          end
        end
      end
      advance_second();
    end else begin
      tick_count = tick_count + 16'd1;
    end
    return {cal_now, elapsed};
  endfunction

  function automatic ccs_pkg::time_t make_time(int y, int mo, int d, int h, int mi, int s);
    ccs_pkg::time_t t;
    t.year   = y[ccs_pkg::YEAR_W-1:0];
    t.month  = mo[ccs_pkg::MONTH_W-1:0];
    t.day    = d[ccs_pkg::DAY_W-1:0];
    t.hour   = h[ccs_pkg::HOUR_W-1:0];
    t.minute = mi[ccs_pkg::MIN_W-1:0];
    t.second = s[ccs_pkg::SEC_W-1:0];
    return t;
  endfunction

  function automatic ccs_pkg::time_t any_time();
    return make_time($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  // well-formed time, optionally just before a day boundary
  function automatic ccs_pkg::time_t plausible_time(bit near_rollover);
    int y;
    int mo;
    int dim;
    y = ($urandom_range(0, 1) == 0) ? CORNER_YEARS[3'($urandom_range(0, 7))]
                                    : $urandom_range(0, 9999);
    mo = $urandom_range(1, 12);
    dim = month_days(mo, y);
    if (near_rollover)
      return make_time(y, mo, dim - $urandom_range(0, 1), 23, 59, $urandom_range(57, 59));
    return make_time(y, mo, $urandom_range(1, dim), $urandom_range(0, 23),
                     $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // sender: inputs change at the falling edge
  task automatic send_word(input logic [ccs_pkg::REQ_W-1:0] req, input ccs_pkg::time_t tm);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.req_type   <= req;
    cmd_ch.new_year   <= tm.year;
    cmd_ch.new_month  <= tm.month;
    cmd_ch.new_day    <= tm.day;
    cmd_ch.new_hour   <= tm.hour;
    cmd_ch.new_minute <= tm.minute;
    cmd_ch.new_second <= tm.second;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (clock_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ccs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      ccs_pkg::CFG_TPS:          tps_cfg = data;
      ccs_pkg::CFG_SUMMER_FIRST: summer_first = data[ccs_pkg::MONTH_W-1:0];
      ccs_pkg::CFG_SUMMER_LAST:  summer_last = data[ccs_pkg::MONTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int tps, input int first, input int last);
    drain();
    write_reg(ccs_pkg::CFG_TPS, tps[ccs_pkg::CFG_DATA_W-1:0]);
    write_reg(ccs_pkg::CFG_SUMMER_FIRST, first[ccs_pkg::CFG_DATA_W-1:0]);
    write_reg(ccs_pkg::CFG_SUMMER_LAST, last[ccs_pkg::CFG_DATA_W-1:0]);
  endtask

  // default prescaler of 1000: no second completes, fix fields are ignored
  task automatic test_reset_state();
    send_word(REQ_TICK, make_time(0, 0, 0, 0, 0, 0));
    send_word(ccs_pkg::REQ_FIX, make_time(2030, 7, 4, 12, 30, 30));
    send_word(REQ_SPARE, make_time(16383, 15, 31, 31, 63, 63));
  endtask

  task automatic test_date_rollover();
    set_config(1, 3, 10);
    send_word(ccs_pkg::REQ_SET, make_time(9999, 12, 31, 23, 59, 59));
    send_word(REQ_TICK, any_time());
    send_word(ccs_pkg::REQ_SET, make_time(2024, 2, 28, 23, 59, 59));
    send_word(REQ_TICK, any_time());
    send_word(ccs_pkg::REQ_SET, make_time(1900, 2, 28, 23, 59, 59));
    send_word(REQ_TICK, any_time());
  endtask

  task automatic test_summer_sync();
    send_word(ccs_pkg::REQ_FIX, make_time(2025, 6, 30, 23, 59, 59));
    send_word(ccs_pkg::REQ_FIX, make_time(2025, 1, 15, 10, 20, 30));
    set_config(1, 12, 1);
    send_word(ccs_pkg::REQ_FIX, make_time(2025, 12, 31, 23, 59, 59));
    set_config(1, 1, 12);
    send_word(ccs_pkg::REQ_FIX, make_time(9999, 12, 31, 23, 0, 0));
  endtask

  task automatic test_odd_fields();
    send_word(ccs_pkg::REQ_SET, make_time(16383, 15, 31, 31, 63, 63));
    send_word(REQ_TICK, any_time());
    send_word(ccs_pkg::REQ_SET, make_time(2025, 0, 31, 23, 59, 59));
    send_word(REQ_TICK, any_time());
    send_word(REQ_SPARE, any_time());
  endtask

  task automatic test_prescaler();
    set_config(0, 3, 10);
    send_word(REQ_TICK, any_time());
    send_word(REQ_TICK, any_time());
    set_config(3, 3, 10);
    repeat (3) send_word(REQ_TICK, any_time());
    set_config(65535, 3, 10);
    repeat (3) send_word(REQ_TICK, any_time());
    // lowered below the current count
    set_config(2, 3, 10);
    send_word(REQ_TICK, any_time());
  endtask

  task automatic run_random_phase(input int tps, input int first, input int last, input int n);
    int r;
    logic [ccs_pkg::REQ_W-1:0] req;
    ccs_pkg::time_t tm;
    set_config(tps, first, last);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        sender_gaps     = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
      end
      if (i == n / 2 && $urandom_range(0, 1) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 50) begin
        req = REQ_TICK;
        tm  = any_time();
      end else if (r < 75) begin
        req = ccs_pkg::REQ_FIX;
        tm  = plausible_time($urandom_range(0, 2) == 0);
      end else if (r < 88) begin
        req = ccs_pkg::REQ_SET;
        tm  = plausible_time($urandom_range(0, 1) == 0);
      end else if (r < 95) begin
        req = ($urandom_range(0, 1) == 0) ? ccs_pkg::REQ_FIX : ccs_pkg::REQ_SET;
        tm  = any_time();
      end else begin
        req = REQ_SPARE;
        tm  = any_time();
      end
      send_word(req, tm);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(1, 3, 10, 90);
    drain();
    run_random_phase(2, 1, 12, 90);
    run_random_phase(4, 12, 1, 80);
    run_random_phase(1, 0, 15, 80);
    run_random_phase(7, 5, 5, 70);
    run_random_phase($urandom_range(1, 3), $urandom_range(1, 12), $urandom_range(1, 12), 90);
  endtask

  // result receiver: ready changes at the falling edge
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
    end
  end

  // result check, then prediction for the accepted word, then watchdog
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (rsp_ch.valid && rsp_ch.ready) begin
        idle_cycles = 0;
        got_reading = {rsp_ch.cur_year, rsp_ch.cur_month, rsp_ch.cur_day, rsp_ch.cur_hour,
                       rsp_ch.cur_minute, rsp_ch.cur_second, rsp_ch.second_elapsed};
        if (clock_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          want_reading = clock_readings.pop_front();
          readings_checked++;
          if (want_reading.elapsed) seconds_seen++;
          if (got_reading !== want_reading) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch at %0t: want %0d-%0d-%0d %0d:%0d:%0d el %0d, ",
                        "got %0d-%0d-%0d %0d:%0d:%0d el %0d"},
                       $realtime, want_reading.tm.year, want_reading.tm.month,
                       want_reading.tm.day, want_reading.tm.hour, want_reading.tm.minute,
                       want_reading.tm.second, want_reading.elapsed,
                       got_reading.tm.year, got_reading.tm.month, got_reading.tm.day,
                       got_reading.tm.hour, got_reading.tm.minute, got_reading.tm.second,
                       got_reading.elapsed);
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        idle_cycles = 0;
        cmd_time = {cmd_ch.new_year, cmd_ch.new_month, cmd_ch.new_day, cmd_ch.new_hour,
                    cmd_ch.new_minute, cmd_ch.new_second};
        clock_readings.push_back(predict_step(cmd_ch.req_type, cmd_time));
        words_sent++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = ccs_pkg::CFG_TPS;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.req_type = REQ_TICK;
    cmd_ch.new_year = '0;
    cmd_ch.new_month = '0;
    cmd_ch.new_day = '0;
    cmd_ch.new_hour = '0;
    cmd_ch.new_minute = '0;
    cmd_ch.new_second = '0;
    cal_now = make_time(2025, 1, 1, 0, 0, 0);
    tick_count = '0;
    tps_cfg = ccs_pkg::TPS_RESET;
    summer_first = ccs_pkg::SUMMER_FIRST_RESET;
    summer_last = ccs_pkg::SUMMER_LAST_RESET;
    fail_count = 0;
    words_sent = 0;
    readings_checked = 0;
    seconds_seen = 0;
    syncs_seen = 0;
    idle_cycles = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_date_rollover();
    test_summer_sync();
    test_odd_fields();
    test_prescaler();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk);
    fail_count += clock_readings.size();
    $display("%0d words sent, %0d results checked, %0d failures", words_sent,
             readings_checked, fail_count);
    $display("%0d seconds elapsed, %0d of them synced from a fix", seconds_seen, syncs_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ccs_pkg.sv
hdl/ccs_cmd_if.sv
hdl/ccs_rsp_if.sv
hdl/ccs_cfg_regs.sv
hdl/ccs_in_stage.sv
hdl/ccs_time_core.sv
hdl/calendar_clock_with_sync_core.sv
verif/calendar_clock_with_sync_core_test.sv
